// ===== hw/rtl/jsse_pkg.sv =====
// ----------------------------------------------------------------------------
// jsse_pkg
// Opcodes, status codes and shared helpers of the stack executor.
// ----------------------------------------------------------------------------
package jsse_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int LOCAL_COUNT_DEF = 256;

    localparam logic [7:0] OP_ICONST_0      = 8'h03;
    localparam logic [7:0] OP_ICONST_1      = 8'h04;
    localparam logic [7:0] OP_ICONST_2      = 8'h05;
    localparam logic [7:0] OP_ICONST_5      = 8'h08;
    localparam logic [7:0] OP_BIPUSH        = 8'h10;
    localparam logic [7:0] OP_ILOAD_0       = 8'h1a;
    localparam logic [7:0] OP_ILOAD_1       = 8'h1b;
    localparam logic [7:0] OP_ILOAD_2       = 8'h1c;
    localparam logic [7:0] OP_ILOAD_3       = 8'h1d;
    localparam logic [7:0] OP_STORE_LOC_0   = 8'h3b;
    localparam logic [7:0] OP_STORE_LOC_1   = 8'h3c;
    localparam logic [7:0] OP_STORE_LOC_2   = 8'h3d;
    localparam logic [7:0] OP_STORE_LOC_3   = 8'h3e;
    localparam logic [7:0] OP_IADD          = 8'h60;
    localparam logic [7:0] OP_ISUB          = 8'h64;
    localparam logic [7:0] OP_IINC          = 8'h84;
    localparam logic [7:0] OP_IFNE          = 8'h9a;
    localparam logic [7:0] OP_IFLE          = 8'h9e;
    localparam logic [7:0] OP_IF_ICMPNE     = 8'ha0;
    localparam logic [7:0] OP_IF_ICMPGE     = 8'ha2;
    localparam logic [7:0] OP_GOTO          = 8'ha7;
    localparam logic [7:0] OP_IRETURN       = 8'hac;
    localparam logic [7:0] OP_RETURN        = 8'hb1;
    localparam logic [7:0] OP_GETSTATIC     = 8'hb2;
    localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hb6;
    localparam logic [7:0] OP_INVOKESTATIC  = 8'hb8;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BRANCH = 3'd1;
    localparam logic [2:0] ST_RETURN = 3'd2;
    localparam logic [2:0] ST_RETVAL = 3'd3;
    localparam logic [2:0] ST_INVOKE = 3'd4;
    localparam logic [2:0] ST_OVER   = 3'd5;
    localparam logic [2:0] ST_UNDER  = 3'd6;
    localparam logic [2:0] ST_UNDEF  = 3'd7;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        sext8 = {{24{b[7]}}, b};
    endfunction

endpackage

// ===== hw/rtl/jsse_locals.sv =====
// ----------------------------------------------------------------------------
// jsse_locals
// Local-variable file: one synchronous read port, one write port, per-entry
// valid bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module jsse_locals #(
    parameter int LOCAL_COUNT = jsse_pkg::LOCAL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(LOCAL_COUNT)-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(LOCAL_COUNT)-1:0] i_wr_addr,
    input  logic [31:0]                    i_wr_data
);

    logic [31:0]            mem [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_vld;
    logic [31:0]            r_rd_data;
    logic                   r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_hit  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 32'd0;

endmodule

// ===== hw/rtl/jvm_subset_stack_executor.sv =====
// ----------------------------------------------------------------------------
// jvm_subset_stack_executor
// Executes one decoded instruction of a small integer JVM subset per input
// transaction and returns one status transaction. Each instruction has an
// accept step and an execute step: in the accept cycle the operand-stack memory
// (two read ports, for the second and third entries) and the local-variable
// file are read into registers; in the execute step the instruction runs
// against those words and a cached top of stack, writes back, and loads the
// output register. A new instruction is taken only once the previous one has
// executed, so instructions do not overlap; a result waiting at the output holds
// one more instruction in the execute stage. No clearing pass after reset: stack
// entries are always written before their values are used, and the local file
// keeps a valid bit per entry.
// ----------------------------------------------------------------------------
module jvm_subset_stack_executor #(
    parameter int STACK_DEPTH = jsse_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = jsse_pkg::LOCAL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_first_operand,
    input  logic [7:0]  i_second_operand,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic signed [15:0] o_branch_offset,
    output logic signed [31:0] o_return_value,
    output logic [15:0] o_pool_index,
    output logic [8:0]  o_stack_depth
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int LAW = $clog2(LOCAL_COUNT);

    logic [31:0]    stk [STACK_DEPTH];

    logic [DW-1:0]  r_depth;
    logic [31:0]    r_tos;
    logic [31:0]    r_rd_b;
    logic [31:0]    r_rd_c;
    logic           r_ex_vld;
    logic [7:0]     r_ex_op;
    logic [7:0]     r_ex_b1;
    logic [7:0]     r_ex_b2;
    logic           r_out_vld;
    logic [2:0]     r_status;
    logic [15:0]    r_boff;
    logic [31:0]    r_rval;
    logic [15:0]    r_pidx;
    logic [8:0]     r_sdepth;

    logic           in_acc;
    logic           ex_go;
    logic [DW-1:0]  addr_b;
    logic [DW-1:0]  addr_c;
    logic [DW-1:0]  addr_w;
    logic [LAW-1:0] lrd_addr;
    logic [1:0]     load_n;
    logic [1:0]     store_n;
    logic [31:0]    lv;

    logic           known;
    logic [1:0]     need;
    logic [1:0]     pop;
    logic           push;
    logic [31:0]    pval;
    logic           taken;
    logic [2:0]     st;
    logic [31:0]    rval;
    logic [15:0]    pidx;
    logic           lwe;
    logic [LAW-1:0] lwa;
    logic [31:0]    lwd;
    logic           under;
    logic           over;
    logic           ok;
    logic           stk_we;
    logic [DW-1:0]  n_depth;
    logic [31:0]    n_tos;
    logic [2:0]     n_status;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_ex_vld;
    assign ex_go      = r_ex_vld && (!r_out_vld || i_out_ready);

    // entries below the cached top live at their stack position
    assign addr_b = r_depth - DW'(2);
    assign addr_c = r_depth - DW'(3);
    assign addr_w = r_depth - DW'(1);

    // local loads are 0x1a..0x1d, local stores are 0x3b..0x3e
    assign load_n   = i_opcode[1:0] - 2'd2;
    assign store_n  = r_ex_op[1:0] + 2'd1;
    assign lrd_addr = (i_opcode == jsse_pkg::OP_IINC) ? i_first_operand[LAW-1:0]
                                                      : LAW'(load_n);

    jsse_locals #(
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_locals (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (lrd_addr),
        .o_rd_data (lv),
        .i_wr_en   (ex_go && ok && lwe),
        .i_wr_addr (lwa),
        .i_wr_data (lwd)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_b <= stk[addr_b[SAW-1:0]];
            r_rd_c <= stk[addr_c[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk[addr_w[SAW-1:0]] <= r_tos;
        end
    end

    always_comb begin
        known = 1'b1;
        need  = 2'd0;
        pop   = 2'd0;
        push  = 1'b0;
        pval  = 32'd0;
        taken = 1'b0;
        st    = jsse_pkg::ST_OK;
        rval  = 32'd0;
        pidx  = 16'd0;
        lwe   = 1'b0;
        lwa   = LAW'(store_n);
        lwd   = r_tos;
        case (r_ex_op)
            jsse_pkg::OP_ICONST_0: begin
                push = 1'b1;
            end
            jsse_pkg::OP_ICONST_1: begin
                push = 1'b1;
                pval = 32'd1;
            end
            jsse_pkg::OP_ICONST_2: begin
                push = 1'b1;
                pval = 32'd2;
            end
            jsse_pkg::OP_ICONST_5: begin
                push = 1'b1;
                pval = 32'd5;
            end
            jsse_pkg::OP_BIPUSH: begin
                push = 1'b1;
                pval = jsse_pkg::sext8(r_ex_b1);
            end
            jsse_pkg::OP_ILOAD_0, jsse_pkg::OP_ILOAD_1,
            jsse_pkg::OP_ILOAD_2, jsse_pkg::OP_ILOAD_3: begin
                push = 1'b1;
                pval = lv;
            end
            jsse_pkg::OP_IADD: begin
                need = 2'd2;
                pop  = 2'd2;
                push = 1'b1;
                pval = r_rd_b + r_tos;
            end
            jsse_pkg::OP_ISUB: begin
                need = 2'd2;
                pop  = 2'd2;
                push = 1'b1;
                pval = r_rd_b - r_tos;
            end
            jsse_pkg::OP_STORE_LOC_0, jsse_pkg::OP_STORE_LOC_1,
            jsse_pkg::OP_STORE_LOC_2, jsse_pkg::OP_STORE_LOC_3: begin
                need = 2'd1;
                pop  = 2'd1;
                lwe  = 1'b1;
            end
            jsse_pkg::OP_IINC: begin
                lwe = (32'(r_ex_b1) < LOCAL_COUNT);
                lwa = r_ex_b1[LAW-1:0];
                lwd = lv + jsse_pkg::sext8(r_ex_b2);
            end
            jsse_pkg::OP_IFNE: begin
                need  = 2'd1;
                pop   = 2'd1;
                taken = (r_tos != 32'd0);
            end
            jsse_pkg::OP_IFLE: begin
                need  = 2'd1;
                pop   = 2'd1;
                taken = ($signed(r_tos) <= 32'sd0);
            end
            jsse_pkg::OP_IF_ICMPNE: begin
                need  = 2'd2;
                pop   = 2'd2;
                taken = (r_rd_b != r_tos);
            end
            jsse_pkg::OP_IF_ICMPGE: begin
                need  = 2'd2;
                pop   = 2'd2;
                taken = ($signed(r_tos) <= $signed(r_rd_b));
            end
            jsse_pkg::OP_GOTO: begin
                taken = 1'b1;
            end
            jsse_pkg::OP_IRETURN: begin
                need = 2'd1;
                st   = jsse_pkg::ST_RETVAL;
                rval = r_tos;
            end
            jsse_pkg::OP_RETURN: begin
                st = jsse_pkg::ST_RETURN;
            end
            jsse_pkg::OP_GETSTATIC: begin
                st = jsse_pkg::ST_OK;
            end
            jsse_pkg::OP_INVOKEVIRTUAL, jsse_pkg::OP_INVOKESTATIC: begin
                st   = jsse_pkg::ST_INVOKE;
                pidx = {r_ex_b1, r_ex_b2};
            end
            default: begin
                known = 1'b0;
            end
        endcase

        if (taken) begin
            st = jsse_pkg::ST_BRANCH;
        end

        under = (r_depth < DW'(need));
        over  = push && (need == 2'd0) && (r_depth == DW'(STACK_DEPTH));
        ok    = known && !under && !over;

        if (!known) begin
            n_status = jsse_pkg::ST_UNDEF;
        end else if (under) begin
            n_status = jsse_pkg::ST_UNDER;
        end else if (over) begin
            n_status = jsse_pkg::ST_OVER;
        end else begin
            n_status = st;
        end

        // a plain push spills the cached top into the memory
        stk_we  = ex_go && ok && push && (need == 2'd0) && (r_depth != '0);
        n_depth = ok ? (r_depth - DW'(pop) + DW'(push)) : r_depth;

        if (push) begin
            n_tos = pval;
        end else if (pop == 2'd1) begin
            n_tos = r_rd_b;
        end else if (pop == 2'd2) begin
            n_tos = r_rd_c;
        end else begin
            n_tos = r_tos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ex_vld <= 1'b1;
            end else if (ex_go) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_go) begin
                r_out_vld <= 1'b1;
                r_depth   <= n_depth;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ex_op <= i_opcode;
            r_ex_b1 <= i_first_operand;
            r_ex_b2 <= i_second_operand;
        end
        if (ex_go) begin
            if (ok) begin
                r_tos <= n_tos;
            end
            r_status <= n_status;
            r_boff   <= (ok && taken) ? {r_ex_b1, r_ex_b2} : 16'd0;
            r_rval   <= ok ? rval : 32'd0;
            r_pidx   <= ok ? pidx : 16'd0;
            r_sdepth <= 9'(n_depth);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_branch_offset = r_boff;
    assign o_return_value  = r_rval;
    assign o_pool_index    = r_pidx;
    assign o_stack_depth   = r_sdepth;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_ex_vld)
        else $error("accepted transaction did not reach execute");

    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_ex_vld))
        else $error("result without an executed instruction");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == jsse_pkg::ST_OVER)
            |-> (o_stack_depth == 9'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");
`endif

endmodule
